>>> sv/pswb_pkg.sv
// Shared package for the periodic sample window buffer.
// Holds field widths, request codes and the controller/datapath handshake types.
// No dependencies.
`default_nettype none

package pswb_pkg;

	localparam int RING_DEPTH_DEF = 64;
	localparam int SAMPLE_W       = 16;
	localparam int COUNT_W        = 7;
	localparam int REQ_W          = 2;
	localparam int OUT_DATA_W     = 24;

	typedef enum logic [REQ_W-1:0] {
		REQ_SAMPLE = 2'd0,
		REQ_TICK   = 2'd1,
		REQ_READ   = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef struct packed {
		logic wr_sample;
		logic tick;
		logic start_win;
		logic rd_en;
		logic advance;
	} pswb_cmd_t;

	typedef struct packed {
		logic snap_zero;
		logic last;
	} pswb_stat_t;

endpackage

`default_nettype wire

>>> sv/periodic_sample_window_buffer.sv
// Periodic sample window buffer, top level.
// Joins the controller (pswb_ctrl) and the datapath (pswb_dp); depends on pswb_pkg.
//
// Usage:
//   Slave channel s_*: s_tuser carries the request kind (sample, period tick,
//   window read); s_tdata carries the sample word for sample requests.
//   Master channel m_*: one transaction per window sample, oldest first;
//   m_tlast marks the final one, m_tuser flags an empty window, which is
//   reported as a single transaction with zero sample and zero count.
//   A sample or tick request completes when it is accepted. In a window
//   read of n samples, each sample passes the registered ring read (state
//   ST_READ) and is then presented (ST_SHOW). An empty window skips the ring
//   read: its transaction is presented in the cycle after the read request is accepted.
//   s_tready is high only while no window readout is in progress.
//   When the receiver stalls, the current transaction holds on m_* and the
//   readout waits; no sample is dropped.
//   Reset clears the pointers, the period count and the snapshot; ring
//   contents stay undefined until written and need no clearing pass.
`default_nettype none

module periodic_sample_window_buffer
	import pswb_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [SAMPLE_W-1:0]   s_tdata,   // [15:0] sample_value
	input  wire logic [REQ_W-1:0]      s_tuser,   // [1:0] req_type
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,   // [15:0] window_sample, [22:16] window_count
	output logic                       m_tuser,   // [0] window_empty
	output logic                       m_tlast
);

	pswb_cmd_t           cmd;
	pswb_stat_t          stat;
	logic [SAMPLE_W-1:0] out_sample;
	logic [COUNT_W-1:0]  out_count;

	pswb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_req    (s_tuser),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pswb_dp #(
		.RING_DEPTH (RING_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_sample  (s_tdata),
		.stat       (stat),
		.out_sample (out_sample),
		.out_count  (out_count),
		.out_empty  (m_tuser)
	);

	assign m_tdata = {1'b0, out_count, out_sample};
	assign m_tlast = stat.last;

endmodule

`default_nettype wire

>>> sv/pswb_ctrl.sv
// Controller for the periodic sample window buffer.
// Sequences request decode and window readout; drives pswb_dp through pswb_cmd_t.
// Depends on pswb_pkg.
`default_nettype none

module pswb_ctrl
	import pswb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [1:0] in_req,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire pswb_stat_t stat,
	output pswb_cmd_t       cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SHOW
	} state_t;

	state_t state_q;
	req_t   req;

	assign req       = req_t'(in_req);
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_SHOW);

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (req)
						REQ_SAMPLE: cmd.wr_sample = 1'b1;
						REQ_TICK:   cmd.tick      = 1'b1;
						REQ_READ:   cmd.start_win = 1'b1;
						default:    cmd           = '0;
					endcase
				end
			end
			ST_READ: cmd.rd_en = 1'b1;
			ST_SHOW: begin
				if (out_ready && !stat.last) begin
					cmd.advance = 1'b1;
				end
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && req == REQ_READ) begin
						state_q <= stat.snap_zero ? ST_SHOW : ST_READ;
					end
				end
				ST_READ: state_q <= ST_SHOW;
				ST_SHOW: begin
					if (out_ready) begin
						state_q <= stat.last ? ST_IDLE : ST_READ;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> sv/pswb_dp.sv
// Datapath for the periodic sample window buffer.
// Holds the sample ring, write pointer, period counters and the readout registers.
// Depends on pswb_pkg; commanded by pswb_ctrl.
`default_nettype none

module pswb_dp
	import pswb_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire pswb_cmd_t           cmd,
	input  wire logic [SAMPLE_W-1:0] in_sample,
	output pswb_stat_t               stat,
	output logic [SAMPLE_W-1:0]      out_sample,
	output logic [COUNT_W-1:0]       out_count,
	output logic                     out_empty
);

	localparam int PTR_W = (RING_DEPTH > 2) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_W = $clog2(RING_DEPTH + 1);
	localparam int SUM_W = $clog2(2 * RING_DEPTH);

	logic [SAMPLE_W-1:0] ring_q [RING_DEPTH];
	logic [SAMPLE_W-1:0] rd_data_q;
	logic [PTR_W-1:0]    wp_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    pc_q;
	logic [CNT_W-1:0]    snap_q;
	logic [CNT_W-1:0]    n_q;
	logic [CNT_W-1:0]    idx_q;
	logic                empty_q;
	logic [SUM_W-1:0]    sum;
	logic [SUM_W-1:0]    start;

	assign sum   = SUM_W'(RING_DEPTH) + SUM_W'(wp_q) - SUM_W'(snap_q);
	assign start = (sum >= SUM_W'(RING_DEPTH)) ? sum - SUM_W'(RING_DEPTH) : sum;

	assign stat.snap_zero = (snap_q == '0);
	assign stat.last      = empty_q || (idx_q == n_q);

	assign out_sample = empty_q ? '0 : rd_data_q;
	assign out_count  = COUNT_W'(n_q);
	assign out_empty  = empty_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_sample) begin
			ring_q[wp_q] <= in_sample;
		end
		if (cmd.rd_en) begin
			rd_data_q <= ring_q[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			pc_q     <= '0;
			snap_q   <= '0;
			rd_ptr_q <= '0;
			n_q      <= '0;
			idx_q    <= '0;
			empty_q  <= 1'b0;
		end else begin
			if (cmd.wr_sample) begin
				wp_q <= (wp_q == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_q + 1'b1;
				if (pc_q != CNT_W'(RING_DEPTH)) begin
					pc_q <= pc_q + 1'b1;
				end
			end
			if (cmd.tick) begin
				snap_q <= pc_q;
				pc_q   <= '0;
			end
			if (cmd.start_win) begin
				n_q      <= snap_q;
				empty_q  <= (snap_q == '0);
				rd_ptr_q <= start[PTR_W-1:0];
				idx_q    <= CNT_W'(1);
			end
			if (cmd.advance) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(RING_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
				idx_q    <= idx_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire
